/* rtl/tdr_pkg.sv */
// Shared types, constants and a helper function for the turtle dead-reckoning block.
`default_nettype none

package tdr_pkg;

  localparam int HALF_TURN    = 180;
  localparam int FULL_TURN    = 2 * HALF_TURN;
  localparam int QUARTER_TURN = HALF_TURN / 2;

  localparam int HEAD_BITS    = 9;
  localparam int REM_BITS     = 7;
  localparam int AMT_MAX_BITS = 16;
  localparam int MOD_STEPS    = AMT_MAX_BITS - 8;

  localparam int CV_BITS      = 34;
  localparam int ANG_BITS     = 26;
  localparam int ANG_FRAC     = 16;
  localparam int ATAN_BITS    = 22;
  localparam int VEC_FRAC     = 30;
  localparam int CORDIC_STEPS = 20;
  localparam int STEP_BITS    = 5;

  localparam int MUL_BITS     = 32;
  localparam int SQ_BITS      = 30;
  localparam int RAD_BITS     = 60;
  localparam int ROOT_BITS    = 30;
  localparam int ROOT_CNT_BITS = 5;
  localparam int RANGE_BITS   = 20;

  localparam logic [1:0] MODE_LEFT    = 2'd0;
  localparam logic [1:0] MODE_RIGHT   = 2'd1;
  localparam logic [1:0] MODE_FORWARD = 2'd2;
  localparam logic [1:0] MODE_BACK    = 2'd3;

  typedef logic [1:0]                  mode_t;
  typedef logic [HEAD_BITS-1:0]        head_t;
  typedef logic [REM_BITS-1:0]         rem_t;
  typedef logic signed [CV_BITS-1:0]   cv_t;
  typedef logic signed [ANG_BITS-1:0]  ang_t;
  typedef logic [2*MUL_BITS-1:0]       prod_t;
  typedef logic [RAD_BITS-1:0]         rad_t;
  typedef logic [ROOT_BITS-1:0]        root_t;
  typedef logic [RANGE_BITS-1:0]       range_t;

  localparam cv_t CORDIC_GAIN = 34'sd652032874;

  localparam logic [ATAN_BITS-1:0] ATAN_DEG [CORDIC_STEPS] = '{
    22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379,
    22'd117305,  22'd58666,   22'd29335,  22'd14668,  22'd7334,
    22'd3667,    22'd1833,    22'd917,    22'd458,    22'd229,
    22'd115,     22'd57,      22'd29,     22'd14,     22'd7
  };

  // Reduces a turn amount modulo a full turn by restoring subtraction.
  function automatic head_t mod_full_turn(input logic [AMT_MAX_BITS-1:0] a);
    logic [AMT_MAX_BITS:0] r;
    logic [AMT_MAX_BITS:0] d;
    r = {1'b0, a};
    for (int k = MOD_STEPS - 1; k >= 0; k--) begin
      d = (AMT_MAX_BITS + 1)'(FULL_TURN) << k;
      if (r >= d) begin
        r = r - d;
      end
    end
    return r[HEAD_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/tdr_cordic.sv */
// Iterative rotation CORDIC giving the cosine and sine of an angle of 0 to 89 degrees.
`default_nettype none

module tdr_cordic (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  tdr_pkg::rem_t rem,
  output logic         done,
  output tdr_pkg::cv_t cos_part,
  output tdr_pkg::cv_t sin_part
);
  import tdr_pkg::*;

  cv_t                  x;
  cv_t                  y;
  ang_t                 z;
  logic [STEP_BITS-1:0] idx;
  logic                 busy;
  cv_t                  xs;
  cv_t                  ys;
  ang_t                 za;
  logic                 at_end;

  assign xs     = x >>> idx;
  assign ys     = y >>> idx;
  assign za     = $signed({{(ANG_BITS-ATAN_BITS){1'b0}}, ATAN_DEG[idx]});
  assign at_end = (idx == STEP_BITS'(CORDIC_STEPS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && at_end;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && at_end) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x   <= CORDIC_GAIN;
      y   <= '0;
      z   <= $signed({{(ANG_BITS-REM_BITS-ANG_FRAC){1'b0}}, rem, {ANG_FRAC{1'b0}}});
      idx <= '0;
    end else if (busy) begin
      if (!z[ANG_BITS-1]) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - za;
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + za;
      end
      idx <= idx + 1'b1;
    end
  end

  assign cos_part = x;
  assign sin_part = y;

endmodule

`default_nettype wire

/* rtl/tdr_sqrt.sv */
// Bit-serial floor square root, one result bit per cycle.
`default_nettype none

module tdr_sqrt (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  tdr_pkg::rad_t radicand,
  output logic          done,
  output tdr_pkg::root_t root
);
  import tdr_pkg::*;

  rad_t                     s;
  rad_t                     r;
  rad_t                     bitm;
  logic [ROOT_CNT_BITS-1:0] cnt;
  logic                     busy;
  logic [RAD_BITS:0]        trial;
  logic                     take;
  logic                     at_end;

  assign trial  = {1'b0, r} + {1'b0, bitm};
  assign take   = ({1'b0, s} >= trial);
  assign at_end = (cnt == ROOT_CNT_BITS'(ROOT_BITS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && at_end;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && at_end) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      s    <= radicand;
      r    <= '0;
      bitm <= rad_t'(1) << (RAD_BITS - 2);
      cnt  <= '0;
    end else if (busy) begin
      if (take) begin
        s <= s - trial[RAD_BITS-1:0];
        r <= (r >> 1) + bitm;
      end else begin
        r <= r >> 1;
      end
      bitm <= bitm >> 2;
      cnt  <= cnt + 1'b1;
    end
  end

  assign root = r[ROOT_BITS-1:0];

endmodule

`default_nettype wire

/* rtl/turtle_dead_reckoning.sv */
// Top level of the turtle dead-reckoning block: sequencer, shared multiplier and position state.
`default_nettype none

// Each item is a turtle command. A turn updates the heading. A move runs 20 rotation steps
// of the CORDIC unit, then two multiply and accumulate pairs on the one shared multiplier.
// An item marked last then does two squares on the same multiplier, a sum, and 30 steps of
// the bit-serial square root, after which the distance is presented and the heading and
// position return to zero. The block takes no new item while one is in progress; a finished
// distance waits in an output register.
module turtle_dead_reckoning #(
  parameter int FRAC_BITS   = 16,
  parameter int AMOUNT_BITS = 10
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cmd_valid,
  output logic                   cmd_stall,
  input  tdr_pkg::mode_t         mode,
  input  logic [AMOUNT_BITS-1:0] amount,
  input  logic                   last,
  output logic                   rng_valid,
  input  logic                   rng_stall,
  output tdr_pkg::range_t        range_from_origin
);
  import tdr_pkg::*;

  localparam int PW = 22 + FRAC_BITS;
  localparam int SH = VEC_FRAC - FRAC_BITS;
  localparam prod_t RND_HALF = prod_t'(1) << (SH - 1);
  localparam logic [PW-1:0] POS_MAX = {1'b0, {(PW-1){1'b1}}};
  localparam logic [PW-1:0] POS_MIN = {1'b1, {(PW-1){1'b0}}};

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_TURN = 4'd1;
  localparam logic [3:0] S_ROT  = 4'd2;
  localparam logic [3:0] S_MULX = 4'd3;
  localparam logic [3:0] S_ACCX = 4'd4;
  localparam logic [3:0] S_MULY = 4'd5;
  localparam logic [3:0] S_ACCY = 4'd6;
  localparam logic [3:0] S_SQX  = 4'd7;
  localparam logic [3:0] S_SQY  = 4'd8;
  localparam logic [3:0] S_SUM  = 4'd9;
  localparam logic [3:0] S_ROOT = 4'd10;
  localparam logic [3:0] S_FIN  = 4'd11;

  logic [3:0]             state;
  head_t                  heading;
  logic [PW-1:0]          pos_x;
  logic [PW-1:0]          pos_y;
  mode_t                  mode_r;
  logic [AMOUNT_BITS-1:0] amt_r;
  logic                   last_r;
  prod_t                  prod;
  logic                   neg;
  rad_t                   sqx;
  root_t                  root_r;

  logic                   accept;
  logic                   is_move;
  logic [1:0]             quad;
  rem_t                   rem;
  logic                   cor_done;
  cv_t                    cos_part;
  cv_t                    sin_part;
  cv_t                    sn;
  cv_t                    cs;
  cv_t                    sel;
  logic [CV_BITS-1:0]     sel_mag;
  logic [MUL_BITS-1:0]    mul_a;
  logic [MUL_BITS-1:0]    mul_b;
  head_t                  turn;
  logic [HEAD_BITS:0]     head_sum;
  head_t                  heading_next;
  prod_t                  rounded;
  logic [PW-1:0]          step_mag;
  logic [PW-1:0]          pos_sel;
  logic [PW:0]            acc;
  logic [PW-1:0]          pos_next;
  logic [PW-1:0]          mag_x;
  logic [PW-1:0]          mag_y;
  logic [SQ_BITS-1:0]     ax;
  logic [SQ_BITS-1:0]     ay;
  logic                   sq_start;
  rad_t                   radicand;
  logic                   sq_done;
  root_t                  root;
  logic [ROOT_BITS:0]     rounded_rng;
  range_t                 rng_sat;
  logic                   fin_fire;

  assign cmd_stall = (state != S_IDLE);
  assign accept    = cmd_valid && !cmd_stall;
  assign is_move   = (mode == MODE_FORWARD) || (mode == MODE_BACK);

  always_comb begin
    if (heading >= head_t'(3 * QUARTER_TURN)) begin
      quad = 2'd3;
      rem  = rem_t'(heading - head_t'(3 * QUARTER_TURN));
    end else if (heading >= head_t'(HALF_TURN)) begin
      quad = 2'd2;
      rem  = rem_t'(heading - head_t'(HALF_TURN));
    end else if (heading >= head_t'(QUARTER_TURN)) begin
      quad = 2'd1;
      rem  = rem_t'(heading - head_t'(QUARTER_TURN));
    end else begin
      quad = 2'd0;
      rem  = rem_t'(heading);
    end
  end

  tdr_cordic u_cordic (
    .clk      (clk),
    .rst      (rst),
    .start    (accept && is_move),
    .rem      (rem),
    .done     (cor_done),
    .cos_part (cos_part),
    .sin_part (sin_part)
  );

  always_comb begin
    case (quad)
      2'd0: begin
        sn = sin_part;
        cs = cos_part;
      end
      2'd1: begin
        sn = cos_part;
        cs = -sin_part;
      end
      2'd2: begin
        sn = -sin_part;
        cs = -cos_part;
      end
      default: begin
        sn = -cos_part;
        cs = sin_part;
      end
    endcase
  end

  assign sel     = (state == S_MULY) ? cs : sn;
  assign sel_mag = sel[CV_BITS-1] ? CV_BITS'(-sel) : CV_BITS'(sel);

  assign mag_x = pos_x[PW-1] ? (~pos_x + 1'b1) : pos_x;
  assign mag_y = pos_y[PW-1] ? (~pos_y + 1'b1) : pos_y;
  assign ax    = mag_x[FRAC_BITS-8 +: SQ_BITS];
  assign ay    = mag_y[FRAC_BITS-8 +: SQ_BITS];

  always_comb begin
    unique case (state)
      S_SQX: begin
        mul_a = MUL_BITS'(ax);
        mul_b = MUL_BITS'(ax);
      end
      S_SQY: begin
        mul_a = MUL_BITS'(ay);
        mul_b = MUL_BITS'(ay);
      end
      default: begin
        mul_a = MUL_BITS'(amt_r);
        mul_b = sel_mag[MUL_BITS-1:0];
      end
    endcase
  end

  assign turn = mod_full_turn(AMT_MAX_BITS'(amt_r));

  always_comb begin
    if (mode_r == MODE_LEFT) begin
      head_sum = {1'b0, heading} + {1'b0, turn};
    end else begin
      head_sum = {1'b0, heading} + (HEAD_BITS + 1)'(FULL_TURN) - {1'b0, turn};
    end
    if (head_sum >= (HEAD_BITS + 1)'(FULL_TURN)) begin
      heading_next = head_t'(head_sum - (HEAD_BITS + 1)'(FULL_TURN));
    end else begin
      heading_next = head_t'(head_sum);
    end
  end

  assign rounded  = (prod + RND_HALF) >> SH;
  assign step_mag = rounded[PW-1:0];
  assign pos_sel  = (state == S_ACCY) ? pos_y : pos_x;

  always_comb begin
    if ((mode_r == MODE_BACK) ^ neg) begin
      acc = {pos_sel[PW-1], pos_sel} - {1'b0, step_mag};
    end else begin
      acc = {pos_sel[PW-1], pos_sel} + {1'b0, step_mag};
    end
    if (acc[PW] != acc[PW-1]) begin
      pos_next = acc[PW] ? POS_MIN : POS_MAX;
    end else begin
      pos_next = acc[PW-1:0];
    end
  end

  assign sq_start = (state == S_SUM);
  assign radicand = sqx + prod[RAD_BITS-1:0];

  tdr_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (radicand),
    .done     (sq_done),
    .root     (root)
  );

  assign rounded_rng = {1'b0, root_r} + (ROOT_BITS + 1)'(128);
  assign rng_sat     = (|rounded_rng[ROOT_BITS:RANGE_BITS+8]) ? {RANGE_BITS{1'b1}}
                                                             : rounded_rng[RANGE_BITS+7:8];
  assign fin_fire    = (state == S_FIN) && (!rng_valid || !rng_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      heading   <= '0;
      pos_x     <= '0;
      pos_y     <= '0;
      rng_valid <= 1'b0;
    end else begin
      if (fin_fire) begin
        rng_valid <= 1'b1;
      end else if (!rng_stall) begin
        rng_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= is_move ? S_ROT : S_TURN;
          end
        end
        S_TURN: begin
          heading <= heading_next;
          state   <= last_r ? S_SQX : S_IDLE;
        end
        S_ROT: begin
          if (cor_done) begin
            state <= S_MULX;
          end
        end
        S_MULX: state <= S_ACCX;
        S_ACCX: begin
          pos_x <= pos_next;
          state <= S_MULY;
        end
        S_MULY: state <= S_ACCY;
        S_ACCY: begin
          pos_y <= pos_next;
          state <= last_r ? S_SQX : S_IDLE;
        end
        S_SQX: state <= S_SQY;
        S_SQY: state <= S_SUM;
        S_SUM: state <= S_ROOT;
        S_ROOT: begin
          if (sq_done) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (fin_fire) begin
            heading <= '0;
            pos_x   <= '0;
            pos_y   <= '0;
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= mode;
      amt_r  <= amount;
      last_r <= last;
    end
    if (state == S_MULX || state == S_MULY || state == S_SQX || state == S_SQY) begin
      prod <= mul_a * mul_b;
      neg  <= sel[CV_BITS-1];
    end
    if (state == S_SQY) begin
      sqx <= prod[RAD_BITS-1:0];
    end
    if (state == S_ROOT && sq_done) begin
      root_r <= root;
    end
    if (fin_fire) begin
      range_from_origin <= rng_sat;
    end
  end

endmodule

`default_nettype wire

/* tb/turtle_dead_reckoning_test.sv */
// Self-checking testbench for the turtle dead-reckoning block with a built-in distance predictor.
`default_nettype none

module turtle_dead_reckoning_test;
  import tdr_pkg::*;

  localparam int FRAC_BITS   = 16;
  localparam int AMOUNT_BITS = 10;
  localparam int POS_BITS    = 22 + FRAC_BITS;
  localparam int SCALE_SH    = VEC_FRAC - FRAC_BITS;
  localparam longint POS_TOP = (longint'(1) <<< (POS_BITS - 1)) - 1;
  localparam longint POS_BOT = -POS_TOP - 1;
  localparam longint RANGE_TOP = (longint'(1) << RANGE_BITS) - 1;
  localparam int AMT_TOP     = (1 << AMOUNT_BITS) - 1;
  localparam int RANDOM_ITEMS = 770;
  localparam int STRAIGHT_MOVES = 1060;
  localparam int HOLD_AT     = 20;
  localparam int HOLD_CYCLES = 1200;
  localparam int DRAIN       = 80;
  localparam int LIMIT       = 2_000_000;

  class range_board;
    head_t heading;
    logic signed [POS_BITS-1:0] pos_x;
    logic signed [POS_BITS-1:0] pos_y;
    range_t pending[$];
    int errors;
    int commands;
    int checked;
    int clamps;
    int saturated;

    function void clear();
      heading = '0;
      pos_x = '0;
      pos_y = '0;
    endfunction

    function void sin_cos(input int h, output longint sn, output longint cs);
      int q;
      longint z, x, y, nx;
      q = h / QUARTER_TURN;
      z = longint'(h % QUARTER_TURN) * 65536;
      x = CORDIC_GAIN;
      y = 0;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        if (z >= 0) begin
          nx = x - (y >>> i);
          y = y + (x >>> i);
          z = z - longint'(ATAN_DEG[i]);
        end else begin
          nx = x + (y >>> i);
          y = y - (x >>> i);
          z = z + longint'(ATAN_DEG[i]);
        end
        x = nx;
      end
      case (q)
        0: begin sn = y;  cs = x;  end
        1: begin sn = x;  cs = -y; end
        2: begin sn = -y; cs = -x; end
        default: begin sn = -x; cs = y; end
      endcase
    endfunction

    function longint scale(input longint amt, input longint v);
      longint p, m;
      p = amt * v;
      m = (p < 0) ? -p : p;
      m = (m + (longint'(1) <<< (SCALE_SH - 1))) >>> SCALE_SH;
      return (p < 0) ? -m : m;
    endfunction

    function longint clamp(input longint v);
      if (v > POS_TOP) begin
        clamps++;
        return POS_TOP;
      end
      if (v < POS_BOT) begin
        clamps++;
        return POS_BOT;
      end
      return v;
    endfunction

    function longint unsigned root_floor(input longint unsigned s);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > s) b = b >> 2;
      while (b != 0) begin
        if (s >= r + b) begin
          s = s - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function range_t distance();
      longint unsigned ax, ay, t, n;
      ax = (pos_x < 0) ? -longint'(pos_x) : longint'(pos_x);
      ay = (pos_y < 0) ? -longint'(pos_y) : longint'(pos_y);
      ax = ax >> (FRAC_BITS - 8);
      ay = ay >> (FRAC_BITS - 8);
      t = root_floor(ax * ax + ay * ay);
      n = (t + 128) >> 8;
      if (n > RANGE_TOP) begin
        saturated++;
        return '1;
      end
      return range_t'(n);
    endfunction

    function void note_cmd(input mode_t m, input logic [AMOUNT_BITS-1:0] a, input logic l);
      int turn;
      longint sn, cs, dx, dy;
      turn = int'(a) % FULL_TURN;
      commands++;
      case (m)
        MODE_LEFT: heading = head_t'((int'(heading) + turn) % FULL_TURN);
        MODE_RIGHT: heading = head_t'((int'(heading) + FULL_TURN - turn) % FULL_TURN);
        default: begin
          sin_cos(int'(heading), sn, cs);
          dx = scale(longint'(a), sn);
          dy = scale(longint'(a), cs);
          if (m == MODE_BACK) begin
            dx = -dx;
            dy = -dy;
          end
          pos_x = POS_BITS'(clamp(longint'(pos_x) + dx));
          pos_y = POS_BITS'(clamp(longint'(pos_y) + dy));
        end
      endcase
      if (l) begin
        pending.push_back(distance());
        clear();
      end
    endfunction

    task report(input string what);
      $display("mismatch at %0t: %s", $time, what);
      errors++;
    endtask

    task check_range(input range_t got);
      range_t want;
      if (pending.size() == 0) begin
        report($sformatf("distance %0d arrived with none expected", got));
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got !== want) begin
        report($sformatf("range_from_origin %0d, expected %0d", got, want));
      end
    endtask
  endclass

  logic clk;
  logic rst;
  logic cmd_valid;
  logic cmd_stall;
  mode_t mode;
  logic [AMOUNT_BITS-1:0] amount;
  logic last;
  logic rng_valid;
  logic rng_stall;
  range_t range_from_origin;

  range_board board;
  bit calm;
  int cycles;

  turtle_dead_reckoning #(
    .FRAC_BITS(FRAC_BITS),
    .AMOUNT_BITS(AMOUNT_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .mode(mode),
    .amount(amount),
    .last(last),
    .rng_valid(rng_valid),
    .rng_stall(rng_stall),
    .range_from_origin(range_from_origin)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("turtle_dead_reckoning_test: errors");
      $finish;
    end
  end

  task automatic send_cmd(input mode_t m, input int a, input bit l);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    mode <= m;
    amount <= AMOUNT_BITS'(a);
    last <= l;
    do @(posedge clk); while (cmd_stall);
    board.note_cmd(m, AMOUNT_BITS'(a), l);
  endtask

  task automatic run_straight(input int turn_left);
    send_cmd(MODE_LEFT, turn_left, 1'b0);
    for (int i = 0; i < STRAIGHT_MOVES; i++) begin
      send_cmd(MODE_FORWARD, AMT_TOP, i == STRAIGHT_MOVES - 1);
    end
  endtask

  initial begin
    int waits;
    bit held;
    rng_stall = 1'b1;
    held = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      waits = calm ? 0 : $urandom_range(0, 4);
      if (!held && board.checked == HOLD_AT) begin
        held = 1'b1;
        waits = HOLD_CYCLES;
      end
      if (waits > 0) begin
        rng_stall <= 1'b1;
        repeat (waits) @(posedge clk);
      end
      rng_stall <= 1'b0;
      do @(posedge clk); while (!rng_valid);
      board.check_range(range_from_origin);
    end
  end

  initial begin
    int len;
    int sent;
    int a;
    board = new;
    calm = 1'b0;
    rst = 1'b1;
    cmd_valid = 1'b0;
    mode = MODE_LEFT;
    amount = '0;
    last = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Short directed walk through every quadrant, large turns and amount extremes.
    send_cmd(MODE_FORWARD, 0, 1'b1);
    send_cmd(MODE_LEFT, AMT_TOP, 1'b0);
    send_cmd(MODE_FORWARD, AMT_TOP, 1'b0);
    send_cmd(MODE_RIGHT, AMT_TOP, 1'b0);
    send_cmd(MODE_BACK, AMT_TOP, 1'b0);
    send_cmd(MODE_LEFT, 89, 1'b0);
    send_cmd(MODE_FORWARD, AMT_TOP, 1'b0);
    send_cmd(MODE_LEFT, 1, 1'b0);
    send_cmd(MODE_FORWARD, 512, 1'b0);
    send_cmd(MODE_LEFT, 90, 1'b0);
    send_cmd(MODE_BACK, 341, 1'b0);
    send_cmd(MODE_LEFT, 90, 1'b0);
    send_cmd(MODE_FORWARD, 1, 1'b0);
    send_cmd(MODE_RIGHT, 271, 1'b0);
    send_cmd(MODE_FORWARD, AMT_TOP, 1'b0);
    send_cmd(MODE_RIGHT, 360, 1'b0);
    send_cmd(MODE_LEFT, 720, 1'b1);
    send_cmd(MODE_RIGHT, 0, 1'b1);
    send_cmd(MODE_BACK, AMT_TOP, 1'b1);
    send_cmd(MODE_LEFT, 180, 1'b0);
    send_cmd(MODE_FORWARD, 682, 1'b1);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      len = $urandom_range(1, 20);
      calm = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < len; k++) begin
        a = $urandom_range(0, 1) ? $urandom_range(0, AMT_TOP) : $urandom_range(0, 359);
        send_cmd(mode_t'($urandom_range(0, 3)), a, k == len - 1);
      end
      sent += len;
    end

    // A long straight run along negative x drives the distance into saturation.
    calm = 1'b1;
    run_straight(270);
    calm = 1'b0;

    cmd_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("Run covered %0d commands and %0d checked distances.", board.commands,
             board.checked);
    $display("Position clamped %0d times; distance saturated %0d times.", board.clamps,
             board.saturated);
    if (board.errors == 0) begin
      $display("turtle_dead_reckoning_test: clean");
    end else begin
      $display("turtle_dead_reckoning_test: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
rtl/tdr_pkg.sv
rtl/tdr_cordic.sv
rtl/tdr_sqrt.sv
rtl/turtle_dead_reckoning.sv
tb/turtle_dead_reckoning_test.sv
